/* src/aes_block_cipher_cbc_unit_defines.svh */
// assertion macros shared by the rtl
`ifndef AES_BLOCK_CIPHER_CBC_UNIT_DEFINES_SVH
`define AES_BLOCK_CIPHER_CBC_UNIT_DEFINES_SVH

`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m: lbl");

`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error("%m: lbl");

`endif

/* src/aes_pkg.sv */
package aes_pkg;

  localparam int unsigned MaxRoundsDefault = 14;

  typedef enum logic [2:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3,
    REG_KEY_LEN = 3'd4,
    REG_MODE = 3'd5,
    REG_IV_HI = 3'd6,
    REG_IV_LO = 3'd7
  } cfg_reg_e;

  localparam logic CMD_ENC = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gmul = p;
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    mix_col = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
               a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
               a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
               xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    inv_mix_col = {
      gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9),
      gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13),
      gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11),
      gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14)};
  endfunction

  // state as four column words, column 0 in the top bits
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [31:0] c;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int k = 0; k < 4; k++)
      for (int j = 0; j < 4; j++) t[4*k+j] = SBOX[b[4*((k+j)%4)+j]];
    for (int k = 0; k < 4; k++) begin
      c = {t[4*k], t[4*k+1], t[4*k+2], t[4*k+3]};
      r[127-32*k -: 32] = last ? c : mix_col(c);
    end
    enc_round = r;
  endfunction

  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [31:0] c;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int k = 0; k < 4; k++)
      for (int j = 0; j < 4; j++) t[4*((k+j)%4)+j] = INV_SBOX[b[4*k+j]];
    for (int k = 0; k < 4; k++) begin
      c = {t[4*k], t[4*k+1], t[4*k+2], t[4*k+3]};
      r[127-32*k -: 32] = last ? c : inv_mix_col(c);
    end
    dec_round = r;
  endfunction

endpackage

/* src/aes_key_sched.sv */
// key expansion, one word a cycle, into both round-key memories
module aes_key_sched import aes_pkg::*; #(
  parameter int unsigned MaxRounds = MaxRoundsDefault,
  localparam int unsigned KeyWords = 4 * (MaxRounds + 1),
  localparam int unsigned AddrW = $clog2(KeyWords),
  localparam int unsigned RndW = $clog2(MaxRounds + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [255:0]     key_i,
  input  logic [1:0]       key_len_i,
  output logic             busy_o,
  output logic [RndW-1:0]  rounds_o,
  input  logic [AddrW-1:0] rd_addr_i,
  input  logic             rd_dec_i,
  output logic [31:0]      rd_data_o
);
  `include "aes_block_cipher_cbc_unit_defines.svh"

  typedef enum logic [1:0] {KS_IDLE, KS_FWD, KS_INV} ks_state_e;

  logic [31:0] enc_mem [KeyWords];
  logic [31:0] dec_mem [KeyWords];
  logic [31:0] win_q [8];
  ks_state_e   state_q;
  logic [AddrW-1:0] idx_q, ridx_q;
  logic [3:0]  nk_q;
  logic [2:0]  kpos_q;
  logic [7:0]  rc_q;
  logic [RndW-1:0] nr_q;
  logic [AddrW-1:0] total_q;
  logic        inv_pend_q;
  logic [AddrW-1:0] inv_dst_q;
  logic        inv_mix_q;
  logic [31:0] enc_rd_q;

  logic [31:0] prev, nxt, tw;
  logic [2:0]  top_w;
  logic [3:0]  nk_sel;
  logic [RndW-1:0] nr_sel;

  always_comb begin
    nk_sel = (key_len_i == 2'd0) ? 4'd4 : (key_len_i == 2'd1) ? 4'd6 : 4'd8;
    nr_sel = RndW'(nk_sel + 4'd6);
    if (32'(nk_sel) + 32'd6 > MaxRounds) begin
      nk_sel = 4'd4;
      nr_sel = RndW'(10);
    end
  end

  assign top_w = 3'(nk_q - 4'd1);

  // win_q holds the last nk words, index nk-1 the newest
  always_comb begin
    prev = win_q[top_w];
    tw = prev;
    if (kpos_q == 3'd0) tw = sub_word({prev[23:0], prev[31:24]}) ^ {rc_q, 24'h0};
    else if (nk_q == 4'd8 && kpos_q == 3'd4) tw = sub_word(prev);
    nxt = win_q[0] ^ tw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= KS_FWD;
      idx_q <= AddrW'(0);
      ridx_q <= AddrW'(0);
      nk_q <= 4'd4;
      kpos_q <= 3'd0;
      rc_q <= 8'h01;
      nr_q <= RndW'(10);
      total_q <= AddrW'(44);
      inv_pend_q <= 1'b0;
      inv_dst_q <= AddrW'(0);
      inv_mix_q <= 1'b0;
      for (int i = 0; i < 8; i++) win_q[i] <= 32'h0;
    end else begin
      inv_pend_q <= 1'b0;
      if (start_i) begin
        state_q <= KS_FWD;
        nk_q <= nk_sel;
        nr_q <= nr_sel;
        total_q <= AddrW'(4 * (32'(nr_sel) + 1));
        idx_q <= AddrW'(0);
        kpos_q <= 3'd0;
        rc_q <= 8'h01;
        for (int i = 0; i < 8; i++)
          win_q[i] <= (i < 32'(nk_sel)) ? key_i[255-32*i -: 32] : 32'h0;
      end else begin
        case (state_q)
          KS_FWD: begin
            // first nk words are the key itself
            if (32'(idx_q) < 32'(nk_q)) begin
              idx_q <= idx_q + AddrW'(1);
            end else begin
              for (int i = 0; i < 7; i++)
                win_q[i] <= (3'(i) == top_w) ? nxt : win_q[i+1];
              if (top_w == 3'd7) win_q[7] <= nxt;
              idx_q <= idx_q + AddrW'(1);
              if (kpos_q == top_w) kpos_q <= 3'd0;
              else kpos_q <= kpos_q + 3'd1;
              if (kpos_q == 3'd0) rc_q <= xtime(rc_q);
            end
            if (idx_q == total_q - AddrW'(1)) begin
              state_q <= KS_INV;
              ridx_q <= AddrW'(0);
            end
          end
          KS_INV: begin
            inv_pend_q <= 1'b1;
            inv_dst_q <= ridx_q;
            inv_mix_q <= (ridx_q >= AddrW'(4)) && (ridx_q < total_q - AddrW'(4));
            ridx_q <= ridx_q + AddrW'(1);
            if (ridx_q == total_q - AddrW'(1)) state_q <= KS_IDLE;
          end
          default: ;
        endcase
      end
    end
  end

  logic [AddrW-1:0] src_addr;
  logic [AddrW-1:0] wr_addr;
  logic [31:0]      wr_word;
  logic             wr_en;
  // decryption word 4r+c takes encryption word 4(nr-r)+c
  assign src_addr = AddrW'(4 * 32'(nr_q)) - {ridx_q[AddrW-1:2], 2'b00} + AddrW'(ridx_q[1:0]);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = idx_q;
    wr_word = nxt;
    if (state_q == KS_FWD && !start_i) begin
      wr_en = 1'b1;
      if (32'(idx_q) < 32'(nk_q)) wr_word = win_q[idx_q[2:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) enc_mem[wr_addr] <= wr_word;
    enc_rd_q <= enc_mem[(state_q == KS_INV) ? src_addr : rd_addr_i];
    if (inv_pend_q) dec_mem[inv_dst_q] <= inv_mix_q ? inv_mix_col(enc_rd_q) : enc_rd_q;
    rd_data_o <= rd_dec_i ? dec_mem[rd_addr_i] : enc_mem[rd_addr_i];
  end

  assign busy_o = (state_q != KS_IDLE) || inv_pend_q;
  assign rounds_o = nr_q;

  `ASSERT_IMPL(a_rounds_ok, clk_i, rst_ni,
    (32'(nr_q) == 10 || 32'(nr_q) == 12 || 32'(nr_q) == 14))
  `ASSERT_IMPL(a_nk_match, clk_i, rst_ni, (32'(nr_q) == 32'(nk_q) + 6))
  `ASSERT_NEVER(a_kpos_range, clk_i, rst_ni, (32'(kpos_q) >= 32'(nk_q)))
endmodule

/* src/aes_block_cipher_cbc_unit.sv */
// an input block runs through all its rounds in ST_RUN, then ST_OUT registers the result and raises output valid
// each round reads its four key words one a cycle and is applied with the fourth word
// one block at a time: a new input beat is taken only after the last result is accepted
// a key write re-expands the schedule: 4*(rounds+1) words then as many inverse
// words, and no input is taken while it runs
// reset clears the registers of this module and expands the all-zero 128-bit key
module aes_block_cipher_cbc_unit import aes_pkg::*; #(
  parameter int unsigned MaxRounds = MaxRoundsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // block_lo, block_hi
  input  logic         s_axis_tuser,   // command
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // result_lo, result_hi
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i
);
  `include "aes_block_cipher_cbc_unit_defines.svh"

  localparam int unsigned KeyWords = 4 * (MaxRounds + 1);
  localparam int unsigned AddrW = $clog2(KeyWords);
  localparam int unsigned RndW = $clog2(MaxRounds + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} state_e;

  logic [63:0]  key_q [4];
  logic [1:0]   klen_q;
  logic         cbc_q;
  logic [63:0]  iv_hi_q, iv_lo_q;
  logic [127:0] chain_q;
  logic         ks_start;
  logic         ks_busy;
  logic [RndW-1:0] nr;
  logic [AddrW-1:0] rd_addr;
  logic [31:0]  rd_data;

  state_e       state_q;
  logic         dec_q;
  logic [127:0] st_q, in_q, out_q;
  logic [RndW-1:0] rnd_q;
  logic [1:0]   col_q;
  logic [127:0] rk_q;
  logic [2:0]   wcnt_q;
  logic [127:0] in_blk;

  // internal block order is hi half in the top bits
  assign in_blk = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

  assign ks_start = cfg_we_i &&
    (cfg_idx_i == REG_KEY0 || cfg_idx_i == REG_KEY1 || cfg_idx_i == REG_KEY2 ||
     cfg_idx_i == REG_KEY3 || cfg_idx_i == REG_KEY_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= 64'h0;
      klen_q <= 2'd0;
      cbc_q <= 1'b0;
      iv_hi_q <= 64'h0;
      iv_lo_q <= 64'h0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY0: key_q[0] <= cfg_data_i;
        REG_KEY1: key_q[1] <= cfg_data_i;
        REG_KEY2: key_q[2] <= cfg_data_i;
        REG_KEY3: key_q[3] <= cfg_data_i;
        REG_KEY_LEN: klen_q <= cfg_data_i[1:0];
        REG_MODE: cbc_q <= cfg_data_i[0];
        REG_IV_HI: iv_hi_q <= cfg_data_i;
        REG_IV_LO: iv_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [255:0] key_next;
  logic [1:0]   klen_next;
  always_comb begin
    key_next = {key_q[0], key_q[1], key_q[2], key_q[3]};
    klen_next = klen_q;
    case (cfg_idx_i)
      REG_KEY0: key_next[255:192] = cfg_data_i;
      REG_KEY1: key_next[191:128] = cfg_data_i;
      REG_KEY2: key_next[127:64] = cfg_data_i;
      REG_KEY3: key_next[63:0] = cfg_data_i;
      REG_KEY_LEN: klen_next = cfg_data_i[1:0];
      default: ;
    endcase
  end

  aes_key_sched #(.MaxRounds(MaxRounds)) u_ks (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ks_start),
    .key_i     (key_next),
    .key_len_i (klen_next),
    .busy_o    (ks_busy),
    .rounds_o  (nr),
    .rd_addr_i (rd_addr),
    .rd_dec_i  (dec_q),
    .rd_data_o (rd_data)
  );

  // key words for round rnd_q are read one column a cycle
  logic [RndW-1:0] fetch_rnd;
  assign rd_addr = AddrW'({fetch_rnd, col_q});
  assign s_axis_tready = (state_q == ST_IDLE) && !ks_busy && !ks_start;

  logic [127:0] rnd_out;
  logic         last;
  assign last = (rnd_q == nr);
  assign rnd_out = dec_q ? dec_round(st_q, last) : enc_round(st_q, last);

  // read data is registered and arrives in the cycle after its address, so rk_q
  // collects the row one word at a time and the round is applied with the fourth word
  assign fetch_rnd = (state_q == ST_IDLE) ? RndW'(0) : rnd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chain_q <= 128'h0;
      rnd_q <= RndW'(0);
      col_q <= 2'd0;
      wcnt_q <= 3'd0;
      dec_q <= 1'b0;
      in_q <= 128'h0;
      st_q <= 128'h0;
      rk_q <= 128'h0;
      out_q <= 128'h0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == REG_IV_HI || cfg_idx_i == REG_IV_LO))
        chain_q <= {(cfg_idx_i == REG_IV_HI) ? cfg_data_i : iv_hi_q,
                    (cfg_idx_i == REG_IV_LO) ? cfg_data_i : iv_lo_q};
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            dec_q <= s_axis_tuser;
            in_q <= in_blk;
            st_q <= (cbc_q && s_axis_tuser == CMD_ENC) ? in_blk ^ chain_q : in_blk;
            rnd_q <= RndW'(0);
            col_q <= 2'd0;
            wcnt_q <= 3'd0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          // gather the four words of round rnd_q, then apply
          if (wcnt_q != 3'd0) rk_q <= {rk_q[95:0], rd_data};
          if (wcnt_q == 3'd4) begin
            if (rnd_q == RndW'(0)) st_q <= st_q ^ {rk_q[95:0], rd_data};
            else st_q <= rnd_out ^ {rk_q[95:0], rd_data};
            if (rnd_q == nr) begin
              state_q <= ST_OUT;
            end
            rnd_q <= rnd_q + RndW'(1);
            col_q <= 2'd0;
            wcnt_q <= 3'd0;
          end else begin
            wcnt_q <= wcnt_q + 3'd1;
            if (col_q != 2'd3) col_q <= col_q + 2'd1;
          end
        end
        ST_OUT: begin
          if (!m_axis_tvalid) begin
            out_q <= (cbc_q && dec_q == CMD_DEC) ? st_q ^ chain_q : st_q;
            if (cbc_q) chain_q <= (dec_q == CMD_DEC) ? in_q : st_q;
          end else if (m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  logic out_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (state_q == ST_OUT && !out_v_q) out_v_q <= 1'b1;
    else if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {out_q[63:0], out_q[127:64]};

  `ASSERT_NEVER(a_no_in_while_busy, clk_i, rst_ni, (s_axis_tready && ks_busy))
  `ASSERT_NEVER(a_out_only_in_out, clk_i, rst_ni, (m_axis_tvalid && state_q != ST_OUT))
  `ASSERT_IMPL(a_round_bound, clk_i, rst_ni, (32'(rnd_q) <= MaxRounds + 1))
endmodule

/* test/tb_aes_block_cipher_cbc_unit.sv */
`timescale 1ns / 100ps

module tb_aes_block_cipher_cbc_unit;
  import aes_pkg::*;

  typedef struct {
    int          phase;
    logic        cmd;
    logic [63:0] hi;
    logic [63:0] lo;
    bit          typed;
    logic [63:0] exp_hi;
    logic [63:0] exp_lo;
  } stim_row_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } aes_block_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [63:0]  cfg_data_i;

  aes_block_cipher_cbc_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // cipher model state
  logic [7:0]  fwd_sub [256];
  logic [7:0]  rev_sub [256];
  logic [63:0] key_words [4];
  logic [1:0]  key_len;
  logic        cbc_on;
  logic [63:0] iv_words [2];
  logic [63:0] chain_words [2];
  logic [31:0] enc_keys [60];
  logic [31:0] dec_keys [60];
  int          num_rounds;

  aes_block_t  pending_blocks [$];
  stim_row_t   dir_rows [$];
  int          fail_count;
  bit          hold_req;
  int          burst_left;

  always #10 clk_i = ~clk_i;

  function automatic logic [7:0] ff_dbl(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] ff_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = ff_dbl(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] ff_recip(logic [7:0] x);
    logic [7:0] r;
    r = 8'h01;
    // x^254 is the field inverse, 0 maps to 0
    for (int i = 0; i < 254; i++) r = ff_mul(r, x);
    return r;
  endfunction

  function automatic logic [7:0] rol8(logic [7:0] b, int n);
    return (b << n) | (b >> (8 - n));
  endfunction

  function automatic void build_sub_tables();
    logic [7:0] v;
    for (int x = 0; x < 256; x++) begin
      v = ff_recip(x[7:0]);
      fwd_sub[x] = v ^ rol8(v, 1) ^ rol8(v, 2) ^ rol8(v, 3) ^ rol8(v, 4) ^ 8'h63;
      rev_sub[fwd_sub[x]] = x[7:0];
    end
  endfunction

  function automatic logic [31:0] sub_bytes32(logic [31:0] w);
    return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
  endfunction

  function automatic logic [31:0] column_mix(logic [31:0] w, bit inverse);
    logic [7:0] a [4];
    logic [7:0] m [4];
    logic [7:0] k [4];
    for (int i = 0; i < 4; i++) a[i] = w[31-8*i -: 8];
    if (inverse) begin
      k = '{8'd14, 8'd11, 8'd13, 8'd9};
    end else begin
      k = '{8'd2, 8'd3, 8'd1, 8'd1};
    end
    // circulant matrix: row i uses coefficient k[(j - i) mod 4] for byte j
    for (int i = 0; i < 4; i++) begin
      m[i] = 8'h00;
      for (int j = 0; j < 4; j++) m[i] ^= ff_mul(a[j], k[(j - i + 4) % 4]);
    end
    return {m[0], m[1], m[2], m[3]};
  endfunction

  function automatic void expand_schedule();
    logic [31:0] kw [8];
    logic [31:0] t;
    logic [7:0]  rc;
    int nk, total;
    nk = (key_len == 2'd0) ? 4 : (key_len == 2'd1) ? 6 : 8;
    num_rounds = nk + 6;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) begin
      kw[2*i]   = key_words[i][63:32];
      kw[2*i+1] = key_words[i][31:0];
    end
    total = 4 * (num_rounds + 1);
    for (int i = 0; i < nk; i++) enc_keys[i] = kw[i];
    for (int i = nk; i < total; i++) begin
      t = enc_keys[i-1];
      if (i % nk == 0) begin
        t = sub_bytes32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = ff_dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_bytes32(t);
      end
      enc_keys[i] = enc_keys[i-nk] ^ t;
    end
    for (int r = 0; r <= num_rounds; r++)
      for (int c = 0; c < 4; c++) begin
        t = enc_keys[4*(num_rounds-r)+c];
        if (r != 0 && r != num_rounds) t = column_mix(t, 1'b1);
        dec_keys[4*r+c] = t;
      end
  endfunction

  function automatic logic [127:0] round_key(bit dec, int r);
    if (dec) return {dec_keys[4*r], dec_keys[4*r+1], dec_keys[4*r+2], dec_keys[4*r+3]};
    return {enc_keys[4*r], enc_keys[4*r+1], enc_keys[4*r+2], enc_keys[4*r+3]};
  endfunction

  // byte i of the state sits at bits 127-8*i
  function automatic logic [127:0] run_cipher(logic [127:0] s, bit dec);
    logic [7:0]   b [16];
    logic [7:0]   t [16];
    logic [31:0]  col;
    logic [127:0] r;
    s ^= round_key(dec, 0);
    for (int rnd = 1; rnd <= num_rounds; rnd++) begin
      for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++) begin
          if (dec) t[4*((c+j)%4)+j] = rev_sub[b[4*c+j]];
          else t[4*c+j] = fwd_sub[b[4*((c+j)%4)+j]];
        end
      for (int c = 0; c < 4; c++) begin
        col = {t[4*c], t[4*c+1], t[4*c+2], t[4*c+3]};
        r[127-32*c -: 32] = (rnd != num_rounds) ? column_mix(col, dec) : col;
      end
      s = r ^ round_key(dec, rnd);
    end
    return s;
  endfunction

  function automatic aes_block_t predict_block(logic cmd, logic [63:0] hi, logic [63:0] lo);
    logic [127:0] s;
    aes_block_t   res;
    bit dec;
    dec = (cmd == CMD_DEC);
    s = {hi, lo};
    if (cbc_on && !dec) s ^= {chain_words[0], chain_words[1]};
    s = run_cipher(s, dec);
    res.hi = s[127:64];
    res.lo = s[63:0];
    if (cbc_on) begin
      if (dec) begin
        res.hi ^= chain_words[0];
        res.lo ^= chain_words[1];
        chain_words[0] = hi;
        chain_words[1] = lo;
      end else begin
        chain_words[0] = res.hi;
        chain_words[1] = res.lo;
      end
    end
    return res;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [63:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
        key_words[idx] = value;
        expand_schedule();
      end
      REG_KEY_LEN: begin
        key_len = value[1:0];
        expand_schedule();
      end
      REG_MODE: cbc_on = value[0];
      default: begin
        if (idx == REG_IV_HI) iv_words[0] = value;
        else iv_words[1] = value;
        chain_words[0] = iv_words[0];
        chain_words[1] = iv_words[1];
      end
    endcase
  endtask

  task automatic wait_drained();
    while (pending_blocks.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // offer one block, hold valid until the beat, then maybe open a gap
  task automatic send_block(logic cmd, logic [63:0] hi, logic [63:0] lo,
                            bit typed, logic [63:0] eh, logic [63:0] el, bit end_burst);
    aes_block_t res;
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {lo, hi};
    do @(posedge clk_i); while (!s_axis_tready);
    res = predict_block(cmd, hi, lo);
    if (typed) begin
      res.hi = eh;
      res.lo = el;
    end
    pending_blocks.push_back(res);
    burst_left--;
    if (end_burst || burst_left <= 0) begin
      s_axis_tvalid <= 1'b0;
      gap = end_burst ? 1 : $urandom_range(1, 8);
      if (burst_left <= 0) burst_left = $urandom_range(1, 24);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 9))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic setup_phase(int ph);
    case (ph)
      1: begin
        write_reg(REG_KEY0, 64'h0001020304050607);
        write_reg(REG_KEY1, 64'h08090a0b0c0d0e0f);
        write_reg(REG_KEY_LEN, 64'd0);
      end
      2: begin
        write_reg(REG_KEY2, 64'h1011121314151617);
        write_reg(REG_KEY_LEN, 64'd1);
      end
      3: begin
        write_reg(REG_KEY3, 64'h18191a1b1c1d1e1f);
        write_reg(REG_KEY_LEN, 64'd2);
      end
      // length code three runs as a 256-bit key
      4: write_reg(REG_KEY_LEN, 64'd3);
      5: begin
        write_reg(REG_KEY0, '1);
        write_reg(REG_KEY1, '1);
        write_reg(REG_KEY_LEN, 64'd0);
        write_reg(REG_MODE, 64'd1);
        write_reg(REG_IV_HI, '1);
        write_reg(REG_IV_LO, 64'h0);
      end
      // leaving cbc keeps the chain for later
      6: write_reg(REG_MODE, 64'd0);
      7: write_reg(REG_MODE, 64'd1);
      default: ;
    endcase
  endtask

  task automatic add_row(int ph, logic cmd, logic [63:0] hi, logic [63:0] lo,
                         bit typed = 0, logic [63:0] eh = 0, logic [63:0] el = 0);
    dir_rows.push_back('{ph, cmd, hi, lo, typed, eh, el});
  endtask

  // receiver: checks beats, stalls on a rotating pattern, with one long hold-off
  initial begin
    int cyc;
    int hold_left;
    aes_block_t want;
    cyc = 0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_blocks.size() == 0) begin
          $error("unexpected result beat %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = pending_blocks.pop_front();
          if (m_axis_tdata[63:0] !== want.hi) begin
            $error("result_hi expected %h actual %h", want.hi, m_axis_tdata[63:0]);
            fail_count++;
          end
          if (m_axis_tdata[127:64] !== want.lo) begin
            $error("result_lo expected %h actual %h", want.lo, m_axis_tdata[127:64]);
            fail_count++;
          end
        end
      end
      cyc++;
      if (hold_req) begin
        hold_req = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case ((cyc / 97) % 3)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= (cyc % 4 != 0);
        endcase
      end
    end
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int cur_phase;
    int sent;
    int n_items;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_ENC;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_KEY0;
    cfg_data_i    = '0;
    fail_count    = 0;
    hold_req      = 0;
    burst_left    = 4;
    build_sub_tables();
    foreach (key_words[i]) key_words[i] = '0;
    key_len = 2'd0;
    cbc_on = 1'b0;
    iv_words = '{64'h0, 64'h0};
    chain_words = '{64'h0, 64'h0};
    expand_schedule();

    // zero key after reset
    add_row(0, CMD_ENC, 64'h0, 64'h0, 1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e);
    add_row(0, CMD_DEC, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1, 64'h0, 64'h0);
    add_row(0, CMD_ENC, '1, '1);
    add_row(0, CMD_DEC, '1, '1);
    add_row(1, CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff,
            1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    add_row(1, CMD_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a,
            1, 64'h0011223344556677, 64'h8899aabbccddeeff);
    add_row(2, CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff,
            1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
    add_row(2, CMD_DEC, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191,
            1, 64'h0011223344556677, 64'h8899aabbccddeeff);
    add_row(3, CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff,
            1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    add_row(3, CMD_DEC, 64'h8ea2b7ca516745bf, 64'heafc49904b496089,
            1, 64'h0011223344556677, 64'h8899aabbccddeeff);
    add_row(4, CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff,
            1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    add_row(4, CMD_DEC, '1, 64'h0);
    add_row(5, CMD_ENC, 64'h0, 64'h0);
    add_row(5, CMD_ENC, '1, '1);
    add_row(5, CMD_DEC, 64'h0123456789abcdef, 64'hfedcba9876543210);
    add_row(5, CMD_DEC, '1, 64'h0);
    add_row(5, CMD_ENC, 64'h8000000000000001, 64'h7ffffffffffffffe);
    add_row(6, CMD_ENC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    add_row(6, CMD_DEC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    add_row(7, CMD_ENC, 64'h0, '1);
    add_row(7, CMD_DEC, '1, 64'h0);
    add_row(7, CMD_ENC, 64'h0f0f0f0f0f0f0f0f, 64'hf0f0f0f0f0f0f0f0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    cur_phase = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].phase != cur_phase) begin
        wait_drained();
        cur_phase = dir_rows[i].phase;
        setup_phase(cur_phase);
      end
      send_block(dir_rows[i].cmd, dir_rows[i].hi, dir_rows[i].lo, dir_rows[i].typed,
                 dir_rows[i].exp_hi, dir_rows[i].exp_lo,
                 i == dir_rows.size() - 1 || dir_rows[i+1].phase != cur_phase);
    end

    sent = 0;
    cur_phase = 0;
    while (sent < 1500) begin
      wait_drained();
      for (int r = 0; r < 4; r++)
        if ($urandom_range(0, 2) == 0) write_reg(cfg_reg_e'(r), rand64());
      if ($urandom_range(0, 2) == 0) write_reg(REG_KEY_LEN, 64'($urandom_range(0, 3)));
      if ($urandom_range(0, 1) == 0) write_reg(REG_MODE, 64'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) == 0) write_reg(REG_IV_HI, rand64());
      if ($urandom_range(0, 2) == 0) write_reg(REG_IV_LO, rand64());
      n_items = $urandom_range(20, 120);
      // one phase with the sink blocked so the unit backs up
      if (cur_phase == 3) hold_req = 1;
      for (int k = 0; k < n_items; k++) begin
        send_block(1'($urandom_range(0, 1)), rand64(), rand64(), 0, '0, '0,
                   k == n_items - 1);
        sent++;
      end
      cur_phase++;
    end

    while (pending_blocks.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/aes_pkg.sv
src/aes_key_sched.sv
src/aes_block_cipher_cbc_unit.sv
test/tb_aes_block_cipher_cbc_unit.sv
